@@ src/dnu_pkg.sv @@
package dnu_pkg;

  localparam logic [7:0] BackslashChar = 8'h5C;
  localparam logic [7:0] ZeroChar      = 8'h30;
  localparam int unsigned MaxResults   = 3;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_ONE   = 2'd2,
    PH_TWO   = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] first_digit;
    logic [3:0] second_digit;
  } esc_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // results of one input word, slot 0 goes out first
  typedef struct packed {
    logic [1:0]                  cnt;
    out_word_t [MaxResults-1:0]  words;
  } dec_res_t;

endpackage

@@ src/dnu_decode.sv @@
module dnu_decode
  import dnu_pkg::*;
(
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  esc_state_t state_i,
  output esc_state_t state_o,
  output dec_res_t   res_o
);

  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] value;
  logic       plain;
  logic [1:0] plain_slot;
  out_word_t  plain_word;

  assign is_digit = (in_byte_i >= ZeroChar) && (in_byte_i <= (ZeroChar + 8'd9));
  assign digit    = in_byte_i[3:0];
  // modulo 256 falls out of the 8-bit sum
  assign value    = 8'(state_i.first_digit) * 8'd100
                  + 8'(state_i.second_digit) * 8'd10
                  + 8'(digit);

  always_comb begin
    state_o    = state_i;
    res_o      = '0;
    plain      = 1'b0;
    plain_slot = 2'd0;
    unique case (state_i.phase)
      PH_PLAIN: begin
        plain = 1'b1;
      end
      PH_ESC: begin
        if (is_digit && !in_last_i) begin
          state_o.first_digit = digit;
          state_o.phase       = PH_ONE;
        end else begin
          res_o.words[0] = '{data: in_byte_i, last: in_last_i};
          res_o.cnt      = 2'd1;
          state_o.phase  = PH_PLAIN;
        end
      end
      PH_ONE: begin
        if (is_digit && !in_last_i) begin
          state_o.second_digit = digit;
          state_o.phase        = PH_TWO;
        end else begin
          // broken escape: flush the held digit, then treat the byte as text
          res_o.words[0] = '{data: ZeroChar + 8'(state_i.first_digit), last: 1'b0};
          res_o.cnt      = 2'd1;
          plain          = 1'b1;
          plain_slot     = 2'd1;
        end
      end
      PH_TWO: begin
        if (is_digit) begin
          res_o.words[0] = '{data: value, last: in_last_i};
          res_o.cnt      = 2'd1;
          state_o.phase  = PH_PLAIN;
        end else begin
          res_o.words[0] = '{data: ZeroChar + 8'(state_i.first_digit), last: 1'b0};
          res_o.words[1] = '{data: ZeroChar + 8'(state_i.second_digit), last: 1'b0};
          res_o.cnt      = 2'd2;
          plain          = 1'b1;
          plain_slot     = 2'd2;
        end
      end
      default: ;
    endcase

    plain_word = '{data: in_byte_i, last: in_last_i};
    if (plain) begin
      if ((in_byte_i == BackslashChar) && !in_last_i) begin
        state_o.phase = PH_ESC;
      end else begin
        state_o.phase = PH_PLAIN;
        unique case (plain_slot)
          2'd0:    res_o.words[0] = plain_word;
          2'd1:    res_o.words[1] = plain_word;
          default: res_o.words[2] = plain_word;
        endcase
        res_o.cnt = plain_slot + 2'd1;
      end
    end

    if (state_o.phase == PH_PLAIN) begin
      state_o.first_digit  = 4'd0;
      state_o.second_digit = 4'd0;
    end
  end

endmodule

@@ src/dnu_out_queue.sv @@
module dnu_out_queue
  import dnu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dec_res_t  push_i,
  input  logic      push_en_i,
  output logic      fits_o,
  output out_word_t head_o,
  output logic      head_vld_o,
  input  logic      head_rdy_i
);

  out_word_t [MaxResults-1:0] ent_q, ent_d;
  logic      [1:0]            cnt_q, cnt_d;
  logic                       pop;
  logic      [1:0]            base;
  logic      [2:0]            fill;
  logic      [1:0]            rel;

  assign head_vld_o = (cnt_q != 2'd0);
  assign head_o     = ent_q[0];
  assign pop        = head_vld_o && head_rdy_i;
  assign base       = cnt_q - {1'b0, pop};
  assign fill       = {1'b0, base} + {1'b0, push_i.cnt};
  assign fits_o     = (fill <= 3'(MaxResults));

  always_comb begin
    ent_d = ent_q;
    rel   = 2'd0;
    // advance on pop
    for (int i = 0; i < MaxResults; i++) begin
      if (pop && (i < MaxResults - 1)) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    if (push_en_i) begin
      for (int i = 0; i < MaxResults; i++) begin
        rel = 2'(i) - base;
        if ((2'(i) >= base) && (3'(i) < fill)) begin
          ent_d[i] = push_i.words[rel];
        end
      end
    end
    cnt_d = push_en_i ? fill[1:0] : base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

@@ src/dns_name_unescape_stream.sv @@
// Decimal-escape decoder for DNS presentation names. Each input word is one
// character; "\DDD" becomes one byte (value modulo 256), "\x" becomes x, and
// broken or unfinished escapes flush their held digits as text. The input word
// is held in a register, decoded in one pass into up to three result words,
// and those are queued in a three-entry output register file. One input word
// is taken per cycle while the receiver is ready and each word yields at most
// one result; words that yield two or three results can hold later input
// while the output queue drains, one word per cycle when the receiver is
// ready. tlast marks the final byte of a name on both sides.
module dns_name_unescape_stream
  import dnu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // out_last
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  esc_state_t state_q, state_d;
  dec_res_t   res;
  logic       fits;
  logic       consume;
  out_word_t  head;

  dnu_decode u_decode (
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .res_o     (res)
  );

  dnu_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .push_en_i  (consume),
    .fits_o     (fits),
    .head_o     (head),
    .head_vld_o (m_axis_tvalid_o),
    .head_rdy_i (m_axis_tready_i)
  );

  assign consume         = in_vld_q && fits;
  assign s_axis_tready_o = !in_vld_q || consume;
  assign m_axis_tdata_o  = head.data;
  assign m_axis_tlast_o  = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '{phase: PH_PLAIN, first_digit: 4'd0, second_digit: 4'd0};
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (consume) begin
        state_q <= state_d;
      end
    end
  end

  // hold the word until the decoder has taken it
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import dnu_pkg::*;

  localparam int unsigned NumInputWords = 410;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  // Tracks the decoder state for every accepted input word and holds the
  // bytes that must come out, oldest first.
  class unescape_scoreboard;
    phase_e      phase;
    logic [3:0]  held_first;
    logic [3:0]  held_second;
    out_word_t   pending_bytes[$];
    int unsigned errors;
    int unsigned words_in;
    int unsigned names_in;
    int unsigned bytes_out;
    int unsigned flush_steps;

    function new();
      phase       = PH_PLAIN;
      held_first  = '0;
      held_second = '0;
      errors      = 0;
      words_in    = 0;
      names_in    = 0;
      bytes_out   = 0;
      flush_steps = 0;
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction

    function void push_byte(logic [7:0] data, logic last);
      out_word_t w;
      w.data = data;
      w.last = last;
      pending_bytes = {pending_bytes, w};
    endfunction

    function void note_input(logic [7:0] data, logic last);
      logic        is_dig;
      logic        as_text;
      int unsigned value;
      int unsigned queued;
      is_dig  = (data >= ZeroChar) && (data <= ZeroChar + 8'd9);
      as_text = 1'b0;
      queued  = pending_bytes.size();
      words_in++;
      if (last) names_in++;
      case (phase)
        PH_PLAIN: as_text = 1'b1;
        PH_ESC: begin
          if (is_dig && !last) begin
            held_first = data[3:0];
            phase      = PH_ONE;
          end else begin
            push_byte(data, last);
            phase = PH_PLAIN;
          end
        end
        PH_ONE: begin
          if (is_dig && !last) begin
            held_second = data[3:0];
            phase       = PH_TWO;
          end else begin
            // broken after one digit: flush it, then treat the byte as text
            push_byte(ZeroChar + 8'(held_first), 1'b0);
            phase   = PH_PLAIN;
            as_text = 1'b1;
          end
        end
        default: begin
          if (is_dig) begin
            value = held_first * 100 + held_second * 10 + data[3:0];
            push_byte(value[7:0], last);
            phase = PH_PLAIN;
          end else begin
            push_byte(ZeroChar + 8'(held_first), 1'b0);
            push_byte(ZeroChar + 8'(held_second), 1'b0);
            phase   = PH_PLAIN;
            as_text = 1'b1;
          end
        end
      endcase
      if (as_text) begin
        if (data == BackslashChar && !last) begin
          phase = PH_ESC;
        end else begin
          push_byte(data, last);
          phase = PH_PLAIN;
        end
      end
      if (phase == PH_PLAIN) begin
        held_first  = '0;
        held_second = '0;
      end
      if (pending_bytes.size() - queued >= 2) flush_steps++;
    endfunction

    task report(string what);
      $display("MISMATCH (output byte %0d): %s", bytes_out, what);
      errors++;
    endtask

    task check_result(logic [7:0] data, logic last);
      out_word_t w;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", data, last));
      end else begin
        w = pending_bytes.pop_front();
        if (w.data !== data || w.last !== last)
          report($sformatf("got byte %02h last %0b, want byte %02h last %0b",
                           data, last, w.data, w.last));
      end
      bytes_out++;
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tlast = 1'b0;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  unescape_scoreboard sb = new();
  in_word_t           char_q[$];
  int unsigned        cycle_cnt = 0;

  dns_name_unescape_stream u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),   // [7:0] in_byte
    .s_axis_tlast_i  (s_axis_tlast),   // in_last
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),   // [7:0] out_byte
    .m_axis_tlast_o  (m_axis_tlast)    // out_last
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] rand_digit();
    return ZeroChar + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b >= ZeroChar && b <= ZeroChar + 8'd9);
    return b;
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == BackslashChar);
    return b;
  endfunction

  function automatic void add_chars(logic [7:0] chars[$]);
    in_word_t w;
    foreach (chars[i]) begin
      w.data = chars[i];
      w.last = (i == chars.size() - 1);
      char_q = {char_q, w};
    end
  endfunction

  // Mostly well-formed names with random content; some are cut short, some
  // are noise heavy on backslashes and digits.
  function automatic void add_random_name();
    logic [7:0]  nm[$];
    int unsigned tokens;
    int unsigned kind;
    tokens = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 2))
          0:       nm = {nm, BackslashChar};
          1:       nm = {nm, rand_digit()};
          default: nm = {nm, 8'($urandom_range(0, 255))};
        endcase
      end
    end else begin
      repeat (tokens) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2: repeat ($urandom_range(1, 4)) nm = {nm, rand_text()};
          3, 4: begin
            nm = {nm, BackslashChar};
            repeat (3) nm = {nm, rand_digit()};
          end
          5: begin
            nm = {nm, BackslashChar};
            nm = {nm, rand_non_digit()};
          end
          6: begin
            nm = {nm, BackslashChar};
            repeat ($urandom_range(1, 2)) nm = {nm, rand_digit()};
            nm = {nm, rand_non_digit()};
          end
          7: nm = {nm, 8'($urandom_range(0, 255))};
          8: begin
            nm = {nm, BackslashChar};
            nm = {nm, BackslashChar};
          end
          default: begin
            // left open; the next token or the end of name cuts it
            nm = {nm, BackslashChar};
            repeat ($urandom_range(0, 2)) nm = {nm, rand_digit()};
          end
        endcase
      end
      if ($urandom_range(0, 7) == 0) nm = nm[0:$urandom_range(0, nm.size() - 1)];
    end
    add_chars(nm);
  endfunction

  task automatic send_word(in_word_t w);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w.data;
    s_axis_tlast  <= w.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(w.data, w.last);
  endtask

  task automatic idle_input(int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drive_all();
    int unsigned burst;
    while (char_q.size() != 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      while (burst != 0 && char_q.size() != 0) begin
        send_word(char_q.pop_front());
        burst--;
      end
      idle_input($urandom_range(1, 8));
    end
  endtask

  // receiver: alternate between always ready, coin flips, one in four and rare stalls
  initial begin
    int unsigned mode;
    int unsigned tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 80)) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (tick % 4 == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d bytes still expected", cycle_cnt, sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    add_chars('{8'h00, BackslashChar, "2", "5", "6"});
    add_chars('{BackslashChar, "9", "9", "9", BackslashChar, BackslashChar, BackslashChar,
                8'hFF});
    add_chars('{BackslashChar, "3", "4", "y", BackslashChar, "5", "6", BackslashChar,
                "1", "x"});
    add_chars('{BackslashChar});
    add_chars('{BackslashChar, "5"});
    add_chars('{BackslashChar, "1", "7"});
    while (char_q.size() < NumInputWords) add_random_name();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    drive_all();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Decoded %0d characters in %0d names into %0d bytes", sb.words_in,
             sb.names_in, sb.bytes_out);
    $display("%0d characters flushed two or more bytes; %0d mismatches", sb.flush_steps,
             sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dnu_pkg.sv
src/dnu_decode.sv
src/dnu_out_queue.sv
src/dns_name_unescape_stream.sv
tb/tb_top.sv
